// ===== src/serial_line_editor_defines.svh =====
// ----------------------------------------------------------------------------
// serial_line_editor_defines
// Assertion macros for the serial line editor. The assertions compile away
// when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SERIAL_LINE_EDITOR_DEFINES_SVH
`define SERIAL_LINE_EDITOR_DEFINES_SVH

`ifndef SYNTH
`define SLE_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("serial_line_editor: assertion failed");
`define SLE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("serial_line_editor: assertion failed");
`else
`define SLE_ASSERT_IMPL(lbl, ante, cons)
`define SLE_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== src/sle_pkg.sv =====
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types, byte codes and result decode for the serial line editor.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam logic [7:0] BYTE_BS  = 8'd8;
  localparam logic [7:0] BYTE_LF  = 8'd10;
  localparam logic [7:0] BYTE_CR  = 8'd13;
  localparam logic [7:0] BYTE_ESC = 8'd27;
  localparam logic [7:0] BYTE_SP  = 8'd32;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    OP_SILENT,
    OP_CHAR,
    OP_BS,
    OP_EOL,
    OP_READ
  } op_kind_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [7:0]  data;
    logic [6:0]  len;
  } op_t;

  typedef struct packed {
    logic push;
    op_t  op;
  } q_wr_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } q_rd_t;

  typedef struct packed {
    logic       echo_valid;
    logic [7:0] echo_byte;
    logic       line_done;
    logic [6:0] line_length;
    logic [7:0] read_char;
    logic       last;
  } res_t;

  function automatic logic storable(input logic [7:0] c);
    return (c == BYTE_SP) ||
           (c >= 8'h30 && c <= 8'h39) ||
           (c >= 8'h41 && c <= 8'h5a) ||
           (c >= 8'h61 && c <= 8'h7a);
  endfunction

  function automatic logic [1:0] last_beat(input op_kind_t kind);
    logic [1:0] n;
    unique case (kind)
      OP_BS:   n = 2'd2;
      OP_EOL:  n = 2'd1;
      default: n = 2'd0;
    endcase
    return n;
  endfunction

  function automatic res_t beat_result(input op_t op, input logic [1:0] beat);
    res_t r;
    r = '0;
    unique case (op.kind)
      OP_CHAR: begin
        r.echo_valid = 1'b1;
        r.echo_byte  = op.data;
        r.last       = 1'b1;
      end
      OP_READ: begin
        r.read_char = op.data;
        r.last      = 1'b1;
      end
      OP_BS: begin
        r.echo_valid = 1'b1;
        r.echo_byte  = (beat == 2'd1) ? BYTE_SP : BYTE_BS;
        r.last       = (beat == 2'd2);
      end
      OP_EOL: begin
        r.echo_valid = 1'b1;
        if (beat == 2'd0) begin
          r.echo_byte = BYTE_CR;
        end else begin
          r.echo_byte   = BYTE_LF;
          r.line_done   = 1'b1;
          r.line_length = op.len;
          r.last        = 1'b1;
        end
      end
      default: begin
        r.last = 1'b1;
      end
    endcase
    return r;
  endfunction

endpackage

// ===== src/sle_req_if.sv =====
// ----------------------------------------------------------------------------
// sle_req_if
// Input channel: received byte or line read command.
// ----------------------------------------------------------------------------
interface sle_req_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] rx_byte;
  logic [6:0] read_index;

  modport source (output valid, command, rx_byte, read_index, input ready);
  modport sink   (input valid, command, rx_byte, read_index, output ready);
endinterface

// ===== src/sle_rsp_if.sv =====
// ----------------------------------------------------------------------------
// sle_rsp_if
// Result channel: echo bytes, line completion and read data.
// ----------------------------------------------------------------------------
interface sle_rsp_if;
  logic       valid;
  logic       ready;
  logic       echo_valid;
  logic [7:0] echo_byte;
  logic       line_done;
  logic [6:0] line_length;
  logic [7:0] read_char;
  logic       last;

  modport source (output valid, echo_valid, echo_byte, line_done, line_length,
                  read_char, last, input ready);
  modport sink   (input valid, echo_valid, echo_byte, line_done, line_length,
                  read_char, last, output ready);
endinterface

// ===== src/sle_front.sv =====
// ----------------------------------------------------------------------------
// sle_front
// Accepts input transfers, tracks escape skip and fill count, owns the line
// store and hands one classified operation per input to the queue.
// ----------------------------------------------------------------------------
module sle_front #(
  parameter int LINE_LEN
) (
  input  logic          clk,
  input  logic          rst,
  sle_req_if.sink       req,
  output sle_pkg::q_wr_t qw,
  input  logic          q_full
);

  localparam int FW = $clog2(LINE_LEN + 1);
  localparam int AW = (LINE_LEN > 1) ? $clog2(LINE_LEN) : 1;

  logic [7:0]    mem [LINE_LEN];
  logic [7:0]    rdata;
  logic [FW-1:0] fill_count, fill_next;
  logic [1:0]    skip_count, skip_next;
  logic          st_valid;
  sle_pkg::op_t  st_op, op_next;
  logic          st_oor;
  logic          accept, we, oor;
  logic [FW+6:0] fill_ext;
  logic [AW+6:0] rix;

  assign req.ready = !st_valid || !q_full;
  assign accept    = req.valid && req.ready;
  assign fill_ext  = {7'd0, fill_count};
  assign rix       = {{AW{1'b0}}, req.read_index};
  assign oor       = {1'b0, req.read_index} >= 8'(LINE_LEN);

  always_comb begin
    fill_next    = fill_count;
    skip_next    = skip_count;
    we           = 1'b0;
    op_next.kind = sle_pkg::OP_SILENT;
    op_next.data = req.rx_byte;
    op_next.len  = fill_ext[6:0];
    if (req.command) begin
      op_next.kind = sle_pkg::OP_READ;
    end else if (skip_count != 2'd0) begin
      skip_next = skip_count - 2'd1;
    end else if (req.rx_byte == sle_pkg::BYTE_ESC) begin
      skip_next = 2'd2;
    end else if (req.rx_byte == sle_pkg::BYTE_BS) begin
      if (fill_count != '0) begin
        fill_next    = fill_count - 1'b1;
        op_next.kind = sle_pkg::OP_BS;
      end
    end else if (req.rx_byte == sle_pkg::BYTE_LF) begin
      fill_next    = '0;
      op_next.kind = sle_pkg::OP_EOL;
    end else if (sle_pkg::storable(req.rx_byte)) begin
      if (fill_count < FW'(LINE_LEN)) begin
        we           = 1'b1;
        fill_next    = fill_count + 1'b1;
        op_next.kind = sle_pkg::OP_CHAR;
      end else begin
        fill_next    = '0;
        op_next.kind = sle_pkg::OP_EOL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid   <= 1'b0;
      fill_count <= '0;
      skip_count <= 2'd0;
    end else if (accept) begin
      st_valid   <= 1'b1;
      fill_count <= fill_next;
      skip_count <= skip_next;
    end else if (st_valid && !q_full) begin
      st_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_op  <= op_next;
      st_oor <= oor;
      rdata  <= mem[rix[AW-1:0]];
      if (we) begin
        mem[fill_count[AW-1:0]] <= req.rx_byte;
      end
    end
  end

  always_comb begin
    qw.push    = st_valid && !q_full;
    qw.op      = st_op;
    if (st_op.kind == sle_pkg::OP_READ) begin
      qw.op.data = st_oor ? 8'd0 : rdata;
    end
  end

endmodule

// ===== src/sle_queue.sv =====
// ----------------------------------------------------------------------------
// sle_queue
// Short FIFO of classified operations between front and back.
// ----------------------------------------------------------------------------
module sle_queue (
  input  logic           clk,
  input  logic           rst,
  input  sle_pkg::q_wr_t qw,
  output logic           q_full,
  output sle_pkg::q_rd_t qr,
  input  logic           pop
);

  localparam int QAW = (sle_pkg::QUEUE_DEPTH > 1) ? $clog2(sle_pkg::QUEUE_DEPTH) : 1;

  sle_pkg::op_t   slots [sle_pkg::QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr, rd_ptr;
  logic [QAW:0]   count;

  assign q_full   = count == (QAW + 1)'(sle_pkg::QUEUE_DEPTH);
  assign qr.valid = count != '0;
  assign qr.op    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (qw.push) begin
        wr_ptr <= (wr_ptr == QAW'(sle_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QAW'(sle_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (qw.push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !qw.push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (qw.push) begin
      slots[wr_ptr] <= qw.op;
    end
  end

endmodule

// ===== src/sle_back.sv =====
// ----------------------------------------------------------------------------
// sle_back
// Expands each operation into its one to three result beats and drives the
// registered result channel.
// ----------------------------------------------------------------------------
module sle_back (
  input  logic           clk,
  input  logic           rst,
  input  sle_pkg::q_rd_t qr,
  output logic           pop,
  sle_rsp_if.source      rsp
);

  sle_pkg::op_t  cur;
  logic          cur_valid;
  logic [1:0]    beat;
  sle_pkg::res_t o_res;
  logic          o_valid;
  logic          load, advance, cur_last;

  assign load     = !o_valid || rsp.ready;
  assign cur_last = beat == sle_pkg::last_beat(cur.kind);
  assign advance  = cur_valid && load;
  assign pop      = qr.valid && (!cur_valid || (advance && cur_last));

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid   <= 1'b0;
      cur_valid <= 1'b0;
      beat      <= 2'd0;
    end else begin
      if (advance) begin
        o_valid <= 1'b1;
      end else if (load) begin
        o_valid <= 1'b0;
      end
      if (pop) begin
        cur_valid <= 1'b1;
        beat      <= 2'd0;
      end else if (advance) begin
        if (cur_last) begin
          cur_valid <= 1'b0;
        end
        beat <= cur_last ? 2'd0 : beat + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      o_res <= sle_pkg::beat_result(cur, beat);
    end
    if (pop) begin
      cur <= qr.op;
    end
  end

  assign rsp.valid       = o_valid;
  assign rsp.echo_valid  = o_res.echo_valid;
  assign rsp.echo_byte   = o_res.echo_byte;
  assign rsp.line_done   = o_res.line_done;
  assign rsp.line_length = o_res.line_length;
  assign rsp.read_char   = o_res.read_char;
  assign rsp.last        = o_res.last;

endmodule

// ===== src/serial_line_editor.sv =====
// ----------------------------------------------------------------------------
// serial_line_editor
// Inputs pass the front stage, queue, back op register and result register.
// One result per cycle while rsp.ready holds; an input takes 1, 2 or 3 beats
// (byte/read/silent, line end, backspace), set by the back result sequencer.
// Inputs are taken every cycle while the two-entry queue has room.
// Reset clears fill count, skip count and all valid flags; line store is kept.
// ----------------------------------------------------------------------------
`include "serial_line_editor_defines.svh"

module serial_line_editor #(
  parameter int LINE_LEN = 80
) (
  input  logic      clk,
  input  logic      rst,
  sle_req_if.sink   req,
  sle_rsp_if.source rsp
);

  sle_pkg::q_wr_t qw;
  sle_pkg::q_rd_t qr;
  logic           q_full;
  logic           pop;

  sle_front #(.LINE_LEN(LINE_LEN)) u_front (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .qw     (qw),
    .q_full (q_full)
  );

  sle_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .qw     (qw),
    .q_full (q_full),
    .qr     (qr),
    .pop    (pop)
  );

  sle_back u_back (
    .clk (clk),
    .rst (rst),
    .qr  (qr),
    .pop (pop),
    .rsp (rsp)
  );

  `SLE_ASSERT_IMPL(a_done_is_lf, rsp.valid && rsp.line_done, rsp.last && rsp.echo_byte == sle_pkg::BYTE_LF)
  `SLE_ASSERT_IMPL(a_quiet_echo, rsp.valid && !rsp.echo_valid, rsp.echo_byte == 8'd0 && rsp.last)
  `SLE_ASSERT_NEXT(a_beats_follow, rsp.valid && rsp.ready && !rsp.last, rsp.valid)

endmodule
